// ===== rtl/core/i2crm_pkg.sv =====
package i2crm_pkg;

  localparam logic [7:0] HALF_RESET = 8'd10;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_SPARE = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_A  = 4'd1,
    PH_START_B  = 4'd2,
    PH_TX_LO    = 4'd3,
    PH_TX_HI    = 4'd4,
    PH_TACK_LO  = 4'd5,
    PH_TACK_HI  = 4'd6,
    PH_RX_LO    = 4'd7,
    PH_RX_HI    = 4'd8,
    PH_MACK_LO  = 4'd9,
    PH_MACK_HI  = 4'd10,
    PH_RS_LO    = 4'd11,
    PH_STOP_LO  = 4'd12,
    PH_STOP_HI  = 4'd13,
    PH_STOP_END = 4'd14
  } phase_t;

  typedef enum logic [1:0] {
    STAGE_ADDR = 2'd0,
    STAGE_REG  = 2'd1,
    STAGE_DATA = 2'd2,
    STAGE_DONE = 2'd3
  } stage_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic [7:0] read_count;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       busy_res;
    logic       nack_seen;
  } status_t;

endpackage

// ===== rtl/core/i2c_register_master.sv =====
// I2C register master, driven one tick per request.
//
// Tick channel (tick_valid / tick_stall / tick): every accepted request is
// one timing tick. It carries the sampled SDA level and, when req_type asks
// for it, a register write or register read. Requests that start a
// transaction while one is running are dropped; the bus sequence goes on.
// Status channel (status_valid / status_stall / status): exactly one status
// request leaves for every tick accepted, in order. It carries the SCL and
// SDA drive levels, a received byte with its valid and last marks, busy and
// the sticky not-acknowledge flag of the current or last transaction.
// status_valid rises in the cycle after acceptance; one tick is taken every
// clock cycle while tick_stall is low. The status register is the only buffer:
// while it holds a request and status_stall is high, tick_stall is high as well.
// cfg_write / cfg_data load the ticks-per-half-bit count (zero acts as one);
// write it only while the block is idle.
// Synchronous reset returns the sequencer to idle, clears the held request
// fields, empties the status register and sets the half period to ten ticks.
module i2c_register_master (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick_valid,
  output logic                tick_stall,
  input  i2crm_pkg::tick_t    tick,
  output logic                status_valid,
  input  logic                status_stall,
  output i2crm_pkg::status_t  status,
  input  logic                cfg_write,
  input  logic [7:0]          cfg_data
);
  import i2crm_pkg::*;

  // Sequencer state
  logic [7:0] half_period;
  phase_t     phase, phase_next;
  stage_t     stage, stage_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] tick_count, tick_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [6:0] held_address;
  logic [7:0] held_register;
  logic [7:0] held_data;
  logic       is_read;
  logic       nack_flag, nack_flag_next;

  // Working view of the state once a new request has been taken in
  logic       accept;
  logic       start;
  phase_t     cur_phase;
  stage_t     cur_stage;
  logic [3:0] cur_bit;
  logic [7:0] cur_bytes;
  logic [7:0] cur_tick;
  logic [7:0] cur_shift;
  logic [6:0] cur_address;
  logic [7:0] cur_register;
  logic [7:0] cur_data;
  logic       cur_read;
  logic       cur_nack;
  logic [7:0] half;
  logic       last_tick;
  logic [3:0] bit_inc;
  logic [7:0] bytes_dec;
  status_t    status_next;

  // One status register parts the two sides: stall only when it is full
  // and the receiver holds it.
  assign tick_stall = status_valid & status_stall;
  assign accept     = tick_valid & ~tick_stall;

  // A request from idle loads its fields and starts in the same tick.
  assign start = (phase == PH_IDLE) &&
                 ((tick.req_type == REQ_WRITE) || (tick.req_type == REQ_READ));

  assign cur_phase    = start ? PH_START_A : phase;
  assign cur_stage    = start ? STAGE_ADDR : stage;
  assign cur_bit      = start ? 4'd0 : bit_index;
  assign cur_bytes    = start ? tick.read_count : bytes_left;
  assign cur_tick     = start ? 8'd0 : tick_count;
  assign cur_shift    = start ? {tick.device_address, 1'b0} : shift_byte;
  assign cur_address  = start ? tick.device_address : held_address;
  assign cur_register = start ? tick.register_address : held_register;
  assign cur_data     = start ? tick.write_data : held_data;
  assign cur_read     = start ? (tick.req_type == REQ_READ) : is_read;
  assign cur_nack     = start ? 1'b0 : nack_flag;

  // Half-bit timer: a half ends once the elapsed count reaches the period.
  assign half      = (half_period == 8'd0) ? 8'd1 : half_period;
  assign last_tick = ({1'b0, cur_tick} + 9'd1) >= {1'b0, half};
  assign bit_inc   = cur_bit + 4'd1;
  assign bytes_dec = (cur_bytes != 8'd0) ? cur_bytes - 8'd1 : cur_bytes;

  // Next state of the bus sequencer
  always_comb begin
    phase_next      = cur_phase;
    stage_next      = cur_stage;
    bit_index_next  = cur_bit;
    bytes_left_next = cur_bytes;
    shift_byte_next = cur_shift;
    nack_flag_next  = cur_nack;
    tick_count_next = cur_tick;
    if (cur_phase != PH_IDLE) begin
      tick_count_next = last_tick ? 8'd0 : cur_tick + 8'd1;
    end
    unique case (cur_phase)
      PH_IDLE: begin
      end
      PH_START_A: begin
        if (last_tick) phase_next = PH_START_B;
      end
      PH_START_B: begin
        if (last_tick) begin
          bit_index_next = 4'd0;
          phase_next     = PH_TX_LO;
        end
      end
      PH_TX_LO: begin
        if (last_tick) phase_next = PH_TX_HI;
      end
      PH_TX_HI: begin
        if (last_tick) begin
          shift_byte_next = {cur_shift[6:0], 1'b0};
          bit_index_next  = bit_inc;
          phase_next      = (bit_inc >= 4'd8) ? PH_TACK_LO : PH_TX_LO;
        end
      end
      PH_TACK_LO: begin
        if (last_tick) phase_next = PH_TACK_HI;
      end
      PH_TACK_HI: begin
        if (last_tick) begin
          if (tick.sda_in) nack_flag_next = 1'b1;
          priority if (cur_stage == STAGE_ADDR) begin
            stage_next      = STAGE_REG;
            shift_byte_next = cur_register;
            bit_index_next  = 4'd0;
            phase_next      = PH_TX_LO;
          end else if (cur_stage == STAGE_REG) begin
            stage_next = STAGE_DATA;
            if (cur_read) begin
              // Repeated start, then the address with the read bit
              shift_byte_next = {cur_address, 1'b1};
              phase_next      = PH_RS_LO;
            end else begin
              shift_byte_next = cur_data;
              bit_index_next  = 4'd0;
              phase_next      = PH_TX_LO;
            end
          end else if (cur_read && (cur_bytes != 8'd0)) begin
            stage_next      = STAGE_DONE;
            shift_byte_next = 8'd0;
            bit_index_next  = 4'd0;
            phase_next      = PH_RX_LO;
          end else begin
            stage_next = STAGE_DONE;
            phase_next = PH_STOP_LO;
          end
        end
      end
      PH_RS_LO: begin
        if (last_tick) phase_next = PH_START_A;
      end
      PH_RX_LO: begin
        if (last_tick) phase_next = PH_RX_HI;
      end
      PH_RX_HI: begin
        if (last_tick) begin
          shift_byte_next = {cur_shift[6:0], tick.sda_in};
          bit_index_next  = bit_inc;
          phase_next      = (bit_inc >= 4'd8) ? PH_MACK_LO : PH_RX_LO;
        end
      end
      PH_MACK_LO: begin
        if (last_tick) phase_next = PH_MACK_HI;
      end
      PH_MACK_HI: begin
        if (last_tick) begin
          bytes_left_next = bytes_dec;
          if (bytes_dec == 8'd0) begin
            phase_next = PH_STOP_LO;
          end else begin
            shift_byte_next = 8'd0;
            bit_index_next  = 4'd0;
            phase_next      = PH_RX_LO;
          end
        end
      end
      PH_STOP_LO: begin
        if (last_tick) phase_next = PH_STOP_HI;
      end
      PH_STOP_HI: begin
        if (last_tick) phase_next = PH_STOP_END;
      end
      PH_STOP_END: begin
        if (last_tick) phase_next = PH_IDLE;
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = 8'd0;
      end
    endcase
  end

  // Line levels and status of this tick
  always_comb begin
    status_next            = '0;
    status_next.scl_out    = 1'b1;
    status_next.sda_out    = 1'b1;
    status_next.busy_res   = 1'b1;
    status_next.nack_seen  = nack_flag_next;
    unique case (cur_phase)
      PH_IDLE: begin
        status_next.busy_res = 1'b0;
      end
      PH_START_A, PH_STOP_END: begin
      end
      PH_START_B: begin
        status_next.sda_out = 1'b0;
      end
      PH_TX_LO: begin
        status_next.scl_out = 1'b0;
        status_next.sda_out = cur_shift[7];
      end
      PH_TX_HI: begin
        status_next.sda_out = cur_shift[7];
      end
      PH_TACK_LO, PH_RX_LO, PH_RS_LO: begin
        // Release SDA for the slave
        status_next.scl_out = 1'b0;
      end
      PH_TACK_HI: begin
      end
      PH_RX_HI: begin
        if (last_tick && (bit_inc >= 4'd8)) begin
          status_next.read_byte  = {cur_shift[6:0], tick.sda_in};
          status_next.read_valid = 1'b1;
          status_next.read_last  = (cur_bytes == 8'd1);
        end
      end
      PH_MACK_LO: begin
        // Acknowledge every byte but the last
        status_next.scl_out = 1'b0;
        status_next.sda_out = (cur_bytes <= 8'd1);
      end
      PH_MACK_HI: begin
        status_next.sda_out = (cur_bytes <= 8'd1);
      end
      PH_STOP_LO: begin
        status_next.scl_out = 1'b0;
        status_next.sda_out = 1'b0;
      end
      PH_STOP_HI: begin
        status_next.sda_out = 1'b0;
      end
      default: begin
        status_next.busy_res = 1'b0;
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_RESET;
    end else if (cfg_write) begin
      half_period <= cfg_data;
    end
  end

  // Advance the sequencer on every accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      stage         <= STAGE_ADDR;
      bit_index     <= 4'd0;
      bytes_left    <= 8'd0;
      tick_count    <= 8'd0;
      shift_byte    <= 8'd0;
      held_address  <= 7'd0;
      held_register <= 8'd0;
      held_data     <= 8'd0;
      is_read       <= 1'b0;
      nack_flag     <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      stage         <= stage_next;
      bit_index     <= bit_index_next;
      bytes_left    <= bytes_left_next;
      tick_count    <= tick_count_next;
      shift_byte    <= shift_byte_next;
      held_address  <= cur_address;
      held_register <= cur_register;
      held_data     <= cur_data;
      is_read       <= cur_read;
      nack_flag     <= nack_flag_next;
    end
  end

  // Status register: load on accept, hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else begin
      status_valid <= accept | (status_valid & status_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

endmodule
